@@ design/ipv_pkg.sv @@
// ============================================================================
// ipv_pkg
// Types and constants shared by the insertion/promotion vector replacement
// unit and its victim selector.
// ============================================================================
package ipv_pkg;

    localparam int WAYS    = 16;
    localparam int DEPTH_W = 4;
    localparam int WAY_W   = 4;
    localparam int CNT_W   = 5;
    localparam int WORD_W  = WAYS * DEPTH_W;

    typedef logic [DEPTH_W-1:0] t_depth;
    typedef logic [WAY_W-1:0]   t_way;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [WORD_W-1:0]  t_word;

    typedef enum logic [1:0] {
        OP_FILL   = 2'd0,
        OP_HIT    = 2'd1,
        OP_VICTIM = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam t_depth PROMO_VEC [0:WAYS] = '{
        4'd0, 4'd0, 4'd1, 4'd0, 4'd3, 4'd0, 4'd1, 4'd2, 4'd1,
        4'd0, 4'd5, 4'd1, 4'd0, 4'd0, 4'd1, 4'd11, 4'd13
    };

    localparam t_depth INSERT_DEPTH = PROMO_VEC[WAYS];

endpackage

@@ design/ipv_victim_sel.sv @@
// ============================================================================
// ipv_victim_sel
// Four-level compare tree over the sixteen way depths of one set. Picks the
// active way with the greatest depth, the lower way winning ties.
// ============================================================================
module ipv_victim_sel import ipv_pkg::*; (
    input  t_word  i_word,
    input  t_count i_active,
    output t_way   o_way
);

    localparam int L1 = WAYS / 2;
    localparam int L2 = WAYS / 4;
    localparam int L3 = WAYS / 8;

    typedef logic [DEPTH_W:0] t_key;

    t_key key0 [WAYS];
    t_key key1 [L1];
    t_key key2 [L2];
    t_key key3 [L3];
    t_way way1 [L1];
    t_way way2 [L2];
    t_way way3 [L3];

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            key0[i] = {(CNT_W'(i) < i_active), i_word[i*DEPTH_W +: DEPTH_W]};
        end
        for (int i = 0; i < L1; i++) begin
            if (key0[2*i+1] > key0[2*i]) begin
                key1[i] = key0[2*i+1];
                way1[i] = WAY_W'(2*i+1);
            end else begin
                key1[i] = key0[2*i];
                way1[i] = WAY_W'(2*i);
            end
        end
        for (int i = 0; i < L2; i++) begin
            if (key1[2*i+1] > key1[2*i]) begin
                key2[i] = key1[2*i+1];
                way2[i] = way1[2*i+1];
            end else begin
                key2[i] = key1[2*i];
                way2[i] = way1[2*i];
            end
        end
        for (int i = 0; i < L3; i++) begin
            if (key2[2*i+1] > key2[2*i]) begin
                key3[i] = key2[2*i+1];
                way3[i] = way2[2*i+1];
            end else begin
                key3[i] = key2[2*i];
                way3[i] = way2[2*i];
            end
        end
        o_way = (key3[1] > key3[0]) ? way3[1] : way3[0];
    end

endmodule

@@ design/ipv_cache_replacement_unit.sv @@
// ============================================================================
// ipv_cache_replacement_unit
// Per-set recency depths, vector insertion/promotion or fill-deep/hit-zero.
// ============================================================================
// For each item the set's depth word is read from the depth memory at the
// accepting edge, then modified and written back in the next cycle, when
// the result is registered. busy is high for that one cycle, so a new item
// cannot be started until the current one has been written back. The result
// strobe o_done is high for exactly one cycle and cannot be held off. After
// reset the depth memory is swept to zero, one set per cycle; busy stays high
// during the sweep while way_count writes are still taken.
module ipv_cache_replacement_unit import ipv_pkg::*; #(
    parameter int SETS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_operation,
    input  logic [5:0] i_set_index,
    input  logic [3:0] i_way,
    output logic       o_done,
    output logic [3:0] o_victim_way
);

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MODIFY} t_state;

    t_state          r_state;
    logic [SW-1:0]   r_clr_addr;
    t_count          r_way_count;
    logic            r_done;
    t_way            r_victim_way;
    t_op             r_op;
    t_way            r_way;
    logic [SW-1:0]   r_set;
    t_word           r_word;
    t_word           r_mem [SETS];

    logic            accept;
    logic [SW-1:0]   n_addr;
    logic            vec_mode;
    t_count          active;
    t_depth          cur_depth;
    t_depth          new_depth;
    t_word           n_word;
    t_way            sel_way;
    logic            mem_we;
    logic [SW-1:0]   mem_waddr;
    t_word           mem_wdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_done = r_done;
    assign o_victim_way = r_victim_way;

    always_comb begin
        n_addr = '0;
        for (int k = 0; k < 64; k++) begin
            if (i_set_index == 6'(k)) begin
                n_addr = SW'(k % SETS);
            end
        end
    end

    assign vec_mode = (r_way_count == CNT_W'(WAYS));

    always_comb begin
        if (r_way_count == '0) begin
            active = CNT_W'(1);
        end else if (r_way_count > CNT_W'(WAYS)) begin
            active = CNT_W'(WAYS);
        end else begin
            active = r_way_count;
        end
    end

    assign cur_depth = r_word[{r_way, 2'b00} +: DEPTH_W];

    always_comb begin
        new_depth = '0;
        case (r_op)
            OP_FILL: new_depth = vec_mode ? INSERT_DEPTH : DEPTH_W'(active - CNT_W'(1));
            OP_HIT:  new_depth = vec_mode ? PROMO_VEC[cur_depth] : '0;
            default: new_depth = '0;
        endcase
    end

    always_comb begin
        n_word = r_word;
        for (int w = 0; w < WAYS; w++) begin
            if (r_way == WAY_W'(w)) begin
                n_word[w*DEPTH_W +: DEPTH_W] = new_depth;
            end
        end
    end

    ipv_victim_sel u_victim_sel (
        .i_word   (r_word),
        .i_active (active),
        .o_way    (sel_way)
    );

    always_comb begin
        mem_we = 1'b0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_MODIFY) begin
            case (r_op) inside
                OP_FILL, OP_HIT: mem_we = 1'b1;
                default:         mem_we = 1'b0;
            endcase
        end
    end

    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_set;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : n_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_word <= r_mem[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= t_op'(i_operation);
            r_way <= i_way;
            r_set <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_way_count  <= CNT_W'(WAYS);
            r_done       <= 1'b0;
            r_victim_way <= '0;
        end else begin
            if (i_cfg_we) begin
                r_way_count <= i_cfg_wdata;
            end
            r_done <= (r_state == S_MODIFY);
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == SW'(SETS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + SW'(1);
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_MODIFY;
                    end
                end
                S_MODIFY: begin
                    r_victim_way <= (r_op == OP_VICTIM) ? sel_way : '0;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_after_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_MODIFY))
        else $error("result strobe without a preceding modify cycle");

    a_accept_to_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MODIFY))
        else $error("accepted item did not enter the modify cycle");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_done)
        else $error("result during the clearing sweep");

    a_zero_for_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_op != OP_VICTIM)) |-> (o_victim_way == '0))
        else $error("non-zero victim for fill, hit or unused operation");

endmodule
